### hw/rtl/cau_pkg.sv
// Shared types and codes for the complex arithmetic unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DataWidth = 32;
  localparam int ProdWidth = 2 * DataWidth;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_SAT      = 2'd2
  } status_e;

  typedef struct packed {
    op_e                         op;
    logic signed [DataWidth-1:0] x_real;
    logic signed [DataWidth-1:0] x_imag;
    logic signed [DataWidth-1:0] y_real;
    logic signed [DataWidth-1:0] y_imag;
  } cau_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] z_real;
    logic signed [DataWidth-1:0] z_imag;
    status_e                     status;
  } cau_out_t;

  // One result part on its way through the divider: sign, early overflow,
  // partial remainder, numerator bits still to bring down, quotient so far.
  typedef struct packed {
    logic                 neg;
    logic                 ovf;
    logic [ProdWidth-1:0] rem;
    logic [DataWidth-1:0] nbits;
    logic [DataWidth-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t                re;
    lane_t                im;
    logic [ProdWidth-1:0] den;
    op_e                  op;
    logic                 dz;
  } div_pipe_t;

endpackage

### hw/rtl/cau_front.sv
// Front end of the complex arithmetic unit: products, sums and lane setup.
// Three register stages; depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cau_pkg::cau_in_t   data_i,
  output logic               valid_o,
  output cau_pkg::div_pipe_t data_o
);
  import cau_pkg::*;

  localparam int NumWidth = 3 * DataWidth + FRAC_BITS + 1;

  // stage 1 registers
  logic [2:0]                  valid_q;
  op_e                         op1_q;
  logic                        dz1_q;
  logic signed [ProdWidth-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, q_rr_q, q_ii_q;
  logic signed [DataWidth:0]   a_r_q, a_i_q;
  // stage 2 registers
  op_e                         op2_q;
  logic                        dz2_q;
  logic signed [ProdWidth:0]   s_r_q, s_i_q;
  logic [ProdWidth-1:0]        den2_q;
  // stage 2 next values
  logic signed [ProdWidth:0]   s_r_d, s_i_d;
  // stage 3
  div_pipe_t                   out_d, out_q;

  // Set up one lane: magnitude, early overflow and divider start values.
  function automatic lane_t lane_init(input logic signed [ProdWidth:0] s,
                                      input logic [ProdWidth-1:0] den,
                                      input op_e op);
    logic [ProdWidth:0] mag;
    logic [ProdWidth:0] shr;
    logic [NumWidth-1:0] num;
    logic [NumWidth-1:0] lim;
    lane_t l;
    mag = s[ProdWidth] ? $unsigned(-s) : $unsigned(s);
    num = NumWidth'(mag) << FRAC_BITS;
    lim = NumWidth'(den) << DataWidth;
    l.neg = s[ProdWidth];
    if (op == OP_DIV) begin
      l.ovf   = (num >= lim);
      l.rem   = ProdWidth'(num >> DataWidth);
      l.nbits = num[DataWidth-1:0];
      l.quo   = '0;
    end else begin
      shr     = (op == OP_MUL) ? (mag >> FRAC_BITS) : mag;
      l.ovf   = |shr[ProdWidth:DataWidth];
      l.rem   = '0;
      l.nbits = '0;
      l.quo   = shr[DataWidth-1:0];
    end
    return l;
  endfunction

  // Form sums of products, or carry the add/subtract result through.
  always_comb begin
    unique case (op1_q)
      OP_MUL: begin
        s_r_d = (ProdWidth+1)'(p_rr_q) - (ProdWidth+1)'(p_ii_q);
        s_i_d = (ProdWidth+1)'(p_ri_q) + (ProdWidth+1)'(p_ir_q);
      end
      OP_DIV: begin
        s_r_d = (ProdWidth+1)'(p_rr_q) + (ProdWidth+1)'(p_ii_q);
        s_i_d = (ProdWidth+1)'(p_ir_q) - (ProdWidth+1)'(p_ri_q);
      end
      default: begin
        s_r_d = (ProdWidth+1)'(a_r_q);
        s_i_d = (ProdWidth+1)'(a_i_q);
      end
    endcase
  end

  always_comb begin
    out_d.re  = lane_init(s_r_q, den2_q, op2_q);
    out_d.im  = lane_init(s_i_q, den2_q, op2_q);
    out_d.den = den2_q;
    out_d.op  = op2_q;
    out_d.dz  = dz2_q;
  end

  // Advance valid bits when the pipeline moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q  <= data_i.op;
      dz1_q  <= (data_i.y_real == '0) && (data_i.y_imag == '0);
      p_rr_q <= data_i.x_real * data_i.y_real;
      p_ii_q <= data_i.x_imag * data_i.y_imag;
      p_ri_q <= data_i.x_real * data_i.y_imag;
      p_ir_q <= data_i.x_imag * data_i.y_real;
      q_rr_q <= data_i.y_real * data_i.y_real;
      q_ii_q <= data_i.y_imag * data_i.y_imag;
      if (data_i.op == OP_SUB) begin
        a_r_q <= (DataWidth+1)'(data_i.x_real) - (DataWidth+1)'(data_i.y_real);
        a_i_q <= (DataWidth+1)'(data_i.x_imag) - (DataWidth+1)'(data_i.y_imag);
      end else begin
        a_r_q <= (DataWidth+1)'(data_i.x_real) + (DataWidth+1)'(data_i.y_real);
        a_i_q <= (DataWidth+1)'(data_i.x_imag) + (DataWidth+1)'(data_i.y_imag);
      end
      op2_q  <= op1_q;
      dz2_q  <= dz1_q;
      s_r_q  <= s_r_d;
      s_i_q  <= s_i_d;
      den2_q <= $unsigned(q_rr_q) + $unsigned(q_ii_q);
      out_q  <= out_d;
    end
  end

  assign valid_o = valid_q[2];
  assign data_o  = out_q;

endmodule

### hw/rtl/cau_div_step.sv
// One restoring-division stage for both result parts of the complex unit.
// Produces one quotient bit per lane per stage; depends on cau_pkg.
`timescale 1ns / 1ps

module cau_div_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cau_pkg::div_pipe_t data_i,
  output logic               valid_o,
  output cau_pkg::div_pipe_t data_o
);
  import cau_pkg::*;

  logic      valid_q;
  div_pipe_t data_d, data_q;

  // Bring down one numerator bit, subtract the divisor if it fits.
  function automatic lane_t lane_step(input lane_t l, input logic [ProdWidth-1:0] den);
    logic [ProdWidth:0] t;
    lane_t r;
    r = l;
    t = {l.rem, l.nbits[DataWidth-1]};
    if (t >= {1'b0, den}) begin
      r.rem = ProdWidth'(t - {1'b0, den});
      r.quo = {l.quo[DataWidth-2:0], 1'b1};
    end else begin
      r.rem = t[ProdWidth-1:0];
      r.quo = {l.quo[DataWidth-2:0], 1'b0};
    end
    r.nbits = {l.nbits[DataWidth-2:0], 1'b0};
    return r;
  endfunction

  // Step divide items only; pass the others unchanged.
  always_comb begin
    data_d = data_i;
    if (data_i.op == OP_DIV) begin
      data_d.re = lane_step(data_i.re, data_i.den);
      data_d.im = lane_step(data_i.im, data_i.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed fixed-point parts.
// Top level; depends on cau_pkg, cau_front and cau_div_step.
//
// Usage: present a request on in_data_i with in_valid_i; it is taken when
// in_ready_o is high. Each request gives exactly one result on out_data_o,
// handed over when out_valid_o and out_ready_i are both high, in order.
// The path has three front stages (products, sums, lane setup), one
// restoring-division stage per quotient bit, and one saturation/output stage.
// Every operation takes the same path.
// Throughput is one request per cycle while the receiver takes results.
// The whole pipeline moves as one: when a result waits and out_ready_i is
// low, every stage holds and in_ready_o drops; nothing is lost or repeated.
// Reset clears all valid bits; the block is empty and ready right after.
// Division by zero returns zero with the divide-by-zero status; any part
// that leaves the signed range saturates and sets the saturated status.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cau_pkg::cau_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cau_pkg::cau_out_t out_data_o
);
  import cau_pkg::*;

  logic      en;
  logic      valid_s [DataWidth+1];
  div_pipe_t data_s  [DataWidth+1];
  logic      out_valid_q;
  cau_out_t  out_d, out_q;
  logic      sat_r, sat_i;
  logic [DataWidth-1:0] val_r, val_i;

  // Clamp a magnitude to the signed range and apply its sign.
  function automatic logic [DataWidth:0] sat_lane(input lane_t l);
    logic [DataWidth-1:0] lim;
    logic [DataWidth-1:0] m;
    logic                 sat;
    lim = l.neg ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
    sat = l.ovf || (l.quo > lim);
    m   = sat ? lim : l.quo;
    return {sat, (l.neg ? (~m + 1'b1) : m)};
  endfunction

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .valid_o(valid_s[0]),
    .data_o (data_s[0])
  );

  // Divider chain, one quotient bit per stage.
  for (genvar g = 0; g < DataWidth; g++) begin : g_div
    cau_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_s[g]),
      .data_i (data_s[g]),
      .valid_o(valid_s[g+1]),
      .data_o (data_s[g+1])
    );
  end

  // Saturate both parts and choose the status.
  always_comb begin
    {sat_r, val_r} = sat_lane(data_s[DataWidth].re);
    {sat_i, val_i} = sat_lane(data_s[DataWidth].im);
    if (data_s[DataWidth].op == OP_DIV && data_s[DataWidth].dz) begin
      out_d.z_real = '0;
      out_d.z_imag = '0;
      out_d.status = STATUS_DIV_ZERO;
    end else begin
      out_d.z_real = val_r;
      out_d.z_imag = val_i;
      out_d.status = (sat_r || sat_i) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[DataWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### test/tb_complex_arithmetic_unit.sv
// Self-checking testbench for the complex arithmetic unit: directed and random
// requests against an exact wide-integer predictor. Depends on cau_pkg and the RTL.
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam int FracBits   = 16;
  localparam int StallLimit = 5000;
  localparam int Latency    = DataWidth + 4;

  typedef logic signed [127:0] wide_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  cau_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  cau_out_t out_data_o;

  cau_out_t expected_q[$];
  int       mismatches;
  int       requests_sent;
  int       results_seen;
  int       div_zero_seen;
  int       sat_seen;
  int       quiet_cycles;
  bit       calm;

  complex_arithmetic_unit #(.FRAC_BITS(FracBits)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp one exact part to the signed data range, flagging overflow.
  function automatic logic [DataWidth-1:0] clamp_part(input wide_t v, inout bit ovf);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (DataWidth - 1)) - 1;
    lo = -(wide_t'(1) <<< (DataWidth - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[DataWidth-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[DataWidth-1:0];
    end
    return v[DataWidth-1:0];
  endfunction

  // Compute the exact complex result; signed division truncates toward zero.
  function automatic cau_out_t complex_result(input cau_in_t req);
    wide_t    xr, xi, yr, yi, zr, zi, den, scale;
    bit       ovf;
    cau_out_t res;
    xr = $signed(req.x_real);
    xi = $signed(req.x_imag);
    yr = $signed(req.y_real);
    yi = $signed(req.y_imag);
    scale = wide_t'(1) <<< FracBits;
    ovf = 1'b0;
    zr = '0;
    zi = '0;
    case (req.op)
      OP_ADD: begin
        zr = xr + yr;
        zi = xi + yi;
      end
      OP_SUB: begin
        zr = xr - yr;
        zi = xi - yi;
      end
      OP_MUL: begin
        zr = (xr * yr - xi * yi) / scale;
        zi = (xr * yi + xi * yr) / scale;
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          res.z_real = '0;
          res.z_imag = '0;
          res.status = STATUS_DIV_ZERO;
          return res;
        end
        zr = ((xr * yr + xi * yi) * scale) / den;
        zi = ((xi * yr - xr * yi) * scale) / den;
      end
    endcase
    res.z_real = clamp_part(zr, ovf);
    res.z_imag = clamp_part(zi, ovf);
    res.status = ovf ? STATUS_SAT : STATUS_OK;
    return res;
  endfunction

  // Hand one request to the block, with random idle cycles ahead of it outside the steady stretch.
  task automatic send_request(input cau_in_t req);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(complex_result(req));
    requests_sent++;
  endtask

  task automatic send_parts(input op_e op, input logic [31:0] xr, input logic [31:0] xi,
                            input logic [31:0] yr, input logic [31:0] yi);
    cau_in_t req;
    req.op     = op;
    req.x_real = xr;
    req.x_imag = xi;
    req.y_real = yr;
    req.y_imag = yi;
    send_request(req);
  endtask

  // Hold the sender until every outstanding result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Pick one operand part: full range, small, zero, an extreme or a small whole number.
  function automatic logic [31:0] pick_part();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 35) return $urandom;
    if (sel < 75) return 32'($signed($urandom_range(2 ** 21)) - 2 ** 20);
    if (sel < 85) return '0;
    if (sel < 90) return 32'h8000_0000;
    if (sel < 95) return 32'h7fff_ffff;
    return 32'($signed($urandom_range(8)) - 4) <<< FracBits;
  endfunction

  task automatic test_directed();
    op_e op;
    op = op.first();
    // each operation on plain values and on the range extremes
    do begin
      send_parts(op, 32'h0001_8000, 32'hfffe_0000, 32'h0000_4000, 32'h0003_0000);
      send_parts(op, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_parts(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      op = op.next();
    end while (op != op.first());
    // divide by zero, with zero and nonzero numerators
    send_parts(OP_DIV, 32'h0001_0000, 32'hffff_0000, '0, '0);
    send_parts(OP_DIV, '0, '0, '0, '0);
    // truncation toward zero on negative quotients and products
    send_parts(OP_DIV, 32'hffff_0000, '0, 32'h0003_0000, '0);
    send_parts(OP_DIV, 32'h0001_0000, '0, '0, 32'hfffd_0000);
    send_parts(OP_MUL, 32'hffff_ffff, '0, 32'h0000_0001, '0);
    send_parts(OP_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
    // tiny divisor overflows, one saturated part only
    send_parts(OP_DIV, 32'h0100_0000, '0, 32'h0000_0001, '0);
    send_parts(OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_parts(OP_SUB, 32'h8000_0000, '0, 32'h0000_0001, '0);
    drain_results();
  endtask

  task automatic test_random(input int count, input bit steady);
    cau_in_t req;
    calm = steady;
    for (int i = 0; i < count; i++) begin
      req.op     = op_e'($urandom_range(3));
      req.x_real = pick_part();
      req.x_imag = pick_part();
      req.y_real = pick_part();
      req.y_imag = pick_part();
      send_request(req);
    end
    calm = 1'b0;
  endtask

  // Drive the receiver: random stalls except in the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 23);
  end

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    cau_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (want.status == STATUS_DIV_ZERO) div_zero_seen++;
        if (want.status == STATUS_SAT) sat_seen++;
        if (out_data_o.z_real !== want.z_real || out_data_o.z_imag !== want.z_imag ||
            out_data_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected re=%h im=%h st=%s, got re=%h im=%h st=%0d",
                     want.z_real, want.z_imag, want.status.name(),
                     out_data_o.z_real, out_data_o.z_imag, out_data_o.status);
        end
      end
    end
  end

  // Abort when neither side moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni && (in_valid_i || expected_q.size() != 0)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    calm          = 1'b0;
    mismatches    = 0;
    requests_sent = 0;
    results_seen  = 0;
    div_zero_seen = 0;
    sat_seen      = 0;
    quiet_cycles  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(700, 1'b0);
    drain_results();
    test_random(300, 1'b1);
    test_random(880, 1'b0);
    drain_results();
    repeat (Latency + 4) @(posedge clk_i);

    if (expected_q.size() != 0) mismatches += expected_q.size();
    $display("covered %0d requests, %0d results (%0d divide-by-zero, %0d saturated)",
             requests_sent, results_seen, div_zero_seen, sat_seen);
    $display("all four operations with receiver stalls, sender gaps and a steady stretch");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
